@@ hdl/grc_pkg.sv @@
// Shared types and constants for the grid ray caster column unit.
package grc_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [2:0] REG_PLAYER_X      = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y      = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X    = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X       = 3'd4;
  localparam logic [2:0] REG_PLANE_Y       = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  localparam logic [1:0] ST_WALL   = 2'd0;
  localparam logic [1:0] ST_NOWALL = 2'd1;
  localparam logic [1:0] ST_WRITE  = 2'd2;

  localparam logic [20:0] DIST_MAX = 21'h1FFFFF;
  localparam logic [15:0] LH_MAX   = 16'hFFFF;
  localparam logic [10:0] SCR_MAX  = 11'd1024;

  typedef enum logic [16:0] {
    S_CLEAR  = 17'b00000000000000001,
    S_IDLE   = 17'b00000000000000010,
    S_CAM    = 17'b00000000000000100,
    S_MULX   = 17'b00000000000001000,
    S_MULY   = 17'b00000000000010000,
    S_DXDIV  = 17'b00000000000100000,
    S_SDXMUL = 17'b00000000001000000,
    S_DYDIV  = 17'b00000000010000000,
    S_SDYMUL = 17'b00000000100000000,
    S_WSTART = 17'b00000001000000000,
    S_STEP   = 17'b00000010000000000,
    S_CHECK  = 17'b00000100000000000,
    S_DIST   = 17'b00001000000000000,
    S_LH     = 17'b00010000000000000,
    S_TEXMUL = 17'b00100000000000000,
    S_TEX    = 17'b01000000000000000,
    S_DONE   = 17'b10000000000000000
  } state_t;

endpackage

@@ hdl/grid_ray_cast_column.sv @@
// Grid ray caster for one screen column: map store, DDA walk and shared divide/multiply.
//
//   channel  | direction | payload
//   s_*      | in        | tuser kind, tdata column/cell_x/cell_y/cell_value
//   m_*      | out       | tuser status, tdata distance, height, rows, texture, side
//   cfg_*    | in        | register index and value, written whenever cfg_we is high
//
// A cast that hits a wall returns its result after five restoring divisions at one bit per
// cycle and the map walk, which takes a STEP and a CHECK state for each cell walked.
// A zero distance skips the height division; a walk that finds no wall ends right after
// the walk.
// A map write goes from idle straight to the output state. After reset a clearing pass
// empties all MAP_SIZE*MAP_SIZE map cells; the last state stalls while m_tvalid is held.
module grid_ray_cast_column #(
  parameter int MAP_SIZE  = 32,
  parameter int TEX_SIZE  = 64,
  parameter int MAX_STEPS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // column[9:0], cell_x[14:10], cell_y[19:15], cell_value[23:20]
  input  logic [grc_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // wall_distance[20:0], line_height[36:21], draw_start[46:37], draw_end[56:47],
  // wall_texture[60:57], tex_column[66:61], hit_side[67], zero[71:68]
  output logic [grc_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import grc_pkg::*;

  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CI    = $clog2(MAP_SIZE);
  localparam int MAXC  = (MAP_SIZE > 32) ? MAP_SIZE : 32;
  localparam int MW    = $clog2(MAXC + 1) + 1;
  localparam int NMW   = $clog2(MAXC) + 17;
  localparam int NW    = NMW + 2;
  localparam int DDW   = NMW + 14;
  localparam int DVW   = 21;
  localparam int CNTW  = $clog2(DDW + 1);
  localparam int RW    = 18;
  localparam int SW    = 31 + $clog2(MAX_STEPS + 1);
  localparam int SCW   = $clog2(MAX_STEPS + 1);
  localparam int TW    = $clog2(TEX_SIZE) + 1;

  state_t state;

  logic [20:0]        player_x, player_y;
  logic signed [15:0] view_dir_x, view_dir_y, plane_x, plane_y;
  logic [10:0]        screen_width, screen_height;
  logic [10:0]        w_c, h_c;

  logic [3:0]    grid_mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, clr_addr;
  logic [3:0]    mem_wdata, cell_q;

  logic [9:0]  col_in, col_q;
  logic [4:0]  cx_in, cy_in;
  logic [3:0]  cv_in;
  logic        accept;

  logic                  div_run;
  logic [DDW-1:0]        div_dd, ld_dd, dd_new;
  logic [DVW-1:0]        div_rem, div_dv, ld_dv, rem_new;
  logic [DVW:0]          rem_sh;
  logic [CNTW-1:0]       div_cnt, ld_n;
  logic                  div_ge, div_active;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  logic signed [15:0]   cam;
  logic signed [RW-1:0] rx, ry;
  logic [RW-2:0]        rx_mag, ry_mag, rd_mag;
  logic                 vx, vy, rd_neg;
  logic [30:0]          dx, dy;
  logic [SW-1:0]        sdx, sdy;
  logic signed [MW-1:0] mx, my, mx_n, my_n;
  logic                 take_x;
  logic [SCW-1:0]       steps;
  logic                 side;
  logic [3:0]           hit_cell;
  logic signed [NW-1:0] num;
  logic [NMW-1:0]       num_mag;
  logic                 dist_zero;

  logic [20:0] r_dist;
  logic [15:0] r_lh;
  logic [9:0]  r_ds, r_de;
  logic [5:0]  r_texcol;
  logic [1:0]  r_status;

  logic [16:0] fx_term, fy_term;
  logic [14:0] lh2, hh_w;
  logic [15:0] de_sum, wall16;
  logic [15+TW:0] tprod;
  logic [TW-1:0]  texx, texm;
  logic           mirror;

  assign w_c = (screen_width == 11'd0) ? 11'd1 :
               (screen_width > SCR_MAX) ? SCR_MAX : screen_width;
  assign h_c = (screen_height == 11'd0) ? 11'd1 :
               (screen_height > SCR_MAX) ? SCR_MAX : screen_height;

  assign col_in = s_tdata[9:0];
  assign cx_in  = s_tdata[14:10];
  assign cy_in  = s_tdata[19:15];
  assign cv_in  = s_tdata[23:20];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign mem_we = (state == S_CLEAR) ||
                  (accept && s_tuser == KIND_WRITE &&
                   9'(cx_in) < 9'(MAP_SIZE) && 9'(cy_in) < 9'(MAP_SIZE));
  assign mem_waddr = (state == S_CLEAR) ? clr_addr :
                     AW'(AW'(cx_in) * AW'(MAP_SIZE) + AW'(cy_in));
  assign mem_wdata = (state == S_CLEAR) ? 4'd0 : cv_in;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    cell_q <= grid_mem[mem_raddr];
  end

  assign rx_mag = rx[RW-1] ? (RW-1)'(-rx) : rx[RW-2:0];
  assign ry_mag = ry[RW-1] ? (RW-1)'(-ry) : ry[RW-2:0];
  assign vx     = (rx != '0);
  assign vy     = (ry != '0);
  assign rd_neg = side ? ry[RW-1] : rx[RW-1];
  assign rd_mag = side ? ry_mag : rx_mag;

  assign num = side ?
    (NW'(my) <<< 16) - NW'(player_y) + (ry[RW-1] ? NW'(65536) : NW'(0)) :
    (NW'(mx) <<< 16) - NW'(player_x) + (rx[RW-1] ? NW'(65536) : NW'(0));
  assign num_mag = num[NW-1] ? NMW'(-num) : NMW'(num);

  assign take_x = vx && (!vy || sdx < sdy);
  assign mx_n = take_x ? (rx[RW-1] ? mx - MW'(1) : mx + MW'(1)) : mx;
  assign my_n = take_x ? my : (ry[RW-1] ? my - MW'(1) : my + MW'(1));
  assign mem_raddr = AW'(AW'(mx_n[CI-1:0]) * AW'(MAP_SIZE) + AW'(my_n[CI-1:0]));

  assign div_active = (state == S_CAM) || (state == S_DXDIV) || (state == S_DYDIV) ||
                      (state == S_DIST) || (state == S_LH && r_dist != '0);
  assign rem_sh  = {div_rem, div_dd[DDW-1]};
  assign div_ge  = rem_sh >= {1'b0, div_dv};
  assign rem_new = div_ge ? DVW'(rem_sh - {1'b0, div_dv}) : DVW'(rem_sh);
  assign dd_new  = {div_dd[DDW-2:0], div_ge};

  always_comb begin
    ld_dd = '0;
    ld_dv = '0;
    ld_n  = '0;
    case (state)
      S_CAM: begin
        ld_dd = DDW'({col_q, 15'd0}) << (DDW - 25);
        ld_dv = DVW'(w_c);
        ld_n  = CNTW'(25);
      end
      S_DXDIV: begin
        ld_dd = DDW'(31'h40000000) << (DDW - 31);
        ld_dv = DVW'(rx_mag);
        ld_n  = CNTW'(31);
      end
      S_DYDIV: begin
        ld_dd = DDW'(31'h40000000) << (DDW - 31);
        ld_dv = DVW'(ry_mag);
        ld_n  = CNTW'(31);
      end
      S_DIST: begin
        ld_dd = DDW'(num_mag) << 14;
        ld_dv = DVW'(rd_mag);
        ld_n  = CNTW'(DDW);
      end
      S_LH: begin
        ld_dd = DDW'({h_c, 16'd0}) << (DDW - 27);
        ld_dv = r_dist;
        ld_n  = CNTW'(27);
      end
      default: begin
        ld_n = '0;
      end
    endcase
  end

  assign fx_term = rx[RW-1] ? {1'b0, player_x[15:0]} : 17'h10000 - {1'b0, player_x[15:0]};
  assign fy_term = ry[RW-1] ? {1'b0, player_y[15:0]} : 17'h10000 - {1'b0, player_y[15:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MULX: begin
        mul_a = 32'(plane_x);
        mul_b = 32'(cam);
      end
      S_MULY: begin
        mul_a = 32'(plane_y);
        mul_b = 32'(cam);
      end
      S_SDXMUL: begin
        mul_a = $signed(32'(fx_term));
        mul_b = $signed(32'(dx));
      end
      S_SDYMUL: begin
        mul_a = $signed(32'(fy_term));
        mul_b = $signed(32'(dy));
      end
      S_TEXMUL: begin
        mul_a = $signed(32'(r_dist));
        mul_b = side ? 32'(rx) : 32'(ry);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign lh2    = r_lh[15:1];
  assign hh_w   = 15'(h_c[10:1]);
  assign de_sum = 16'(hh_w) + 16'(lh2);
  assign wall16 = (side ? player_x[15:0] : player_y[15:0]) + mul_p[29:14];
  assign tprod  = (16 + TW)'(wall16) * (16 + TW)'(TEX_SIZE);
  assign texx   = tprod[15+TW:16];
  assign mirror = (!side && vx && !rx[RW-1]) || (side && ry[RW-1]);
  assign texm   = mirror ? TW'(TEX_SIZE) - texx - TW'(1) : texx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      div_run      <= 1'b0;
      m_tvalid     <= 1'b0;
      player_x     <= '0;
      player_y     <= '0;
      view_dir_x   <= 16'sd16384;
      view_dir_y   <= '0;
      plane_x      <= '0;
      plane_y      <= 16'sd10813;
      screen_width <= 11'd640;
      screen_height <= 11'd480;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PLAYER_X:      player_x <= cfg_data;
          REG_PLAYER_Y:      player_y <= cfg_data;
          REG_VIEW_DIR_X:    view_dir_x <= cfg_data[15:0];
          REG_VIEW_DIR_Y:    view_dir_y <= cfg_data[15:0];
          REG_PLANE_X:       plane_x <= cfg_data[15:0];
          REG_PLANE_Y:       plane_y <= cfg_data[15:0];
          REG_SCREEN_WIDTH:  screen_width <= cfg_data[10:0];
          REG_SCREEN_HEIGHT: screen_height <= cfg_data[10:0];
          default: begin
          end
        endcase
      end

      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      if (div_active) begin
        if (!div_run) begin
          div_run <= 1'b1;
          div_dd  <= ld_dd;
          div_rem <= '0;
          div_dv  <= ld_dv;
          div_cnt <= ld_n;
        end else if (div_cnt != '0) begin
          div_dd  <= dd_new;
          div_rem <= rem_new;
          div_cnt <= div_cnt - CNTW'(1);
        end else begin
          div_run <= 1'b0;
        end
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_WRITE) begin
              r_status <= ST_WRITE;
              state    <= S_DONE;
            end else begin
              col_q <= (11'(col_in) > w_c - 11'd1) ? 10'(w_c - 11'd1) : col_in;
              mx    <= MW'(player_x[20:16]);
              my    <= MW'(player_y[20:16]);
              state <= S_CAM;
            end
          end
        end
        S_CAM: begin
          if (div_run && div_cnt == '0) begin
            cam   <= $signed({1'b0, div_dd[14:0]}) - 16'sd16384;
            state <= S_MULX;
          end
        end
        S_MULX: begin
          state <= S_MULY;
        end
        S_MULY: begin
          rx    <= RW'(view_dir_x) + $signed(mul_p[31:14]);
          state <= S_DXDIV;
        end
        S_DXDIV: begin
          if (!div_run) begin
            ry <= RW'(view_dir_y) + $signed(mul_p[31:14]);
          end else if (div_cnt == '0) begin
            dx    <= div_dd[30:0];
            state <= S_SDXMUL;
          end
        end
        S_SDXMUL: begin
          state <= S_DYDIV;
        end
        S_DYDIV: begin
          if (!div_run) begin
            sdx <= SW'(mul_p[46:16]);
          end else if (div_cnt == '0) begin
            dy    <= div_dd[30:0];
            state <= S_SDYMUL;
          end
        end
        S_SDYMUL: begin
          state <= S_WSTART;
        end
        S_WSTART: begin
          sdy   <= SW'(mul_p[46:16]);
          steps <= '0;
          if (vx || vy) begin
            state <= S_STEP;
          end else begin
            r_status <= ST_NOWALL;
            state    <= S_DONE;
          end
        end
        S_STEP: begin
          if (take_x) begin
            sdx  <= sdx + SW'(dx);
            side <= 1'b0;
          end else begin
            sdy  <= sdy + SW'(dy);
            side <= 1'b1;
          end
          mx    <= mx_n;
          my    <= my_n;
          steps <= steps + SCW'(1);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (mx < 0 || mx >= MW'(MAP_SIZE) || my < 0 || my >= MW'(MAP_SIZE)) begin
            r_status <= ST_NOWALL;
            state    <= S_DONE;
          end else if (cell_q != 4'd0) begin
            hit_cell <= cell_q;
            state    <= S_DIST;
          end else if (steps == SCW'(MAX_STEPS)) begin
            r_status <= ST_NOWALL;
            state    <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_DIST: begin
          if (!div_run) begin
            dist_zero <= (num[NW-1] != rd_neg) && (num != '0);
          end else if (div_cnt == '0) begin
            if (dist_zero) begin
              r_dist <= '0;
            end else if (div_dd > DDW'(DIST_MAX)) begin
              r_dist <= DIST_MAX;
            end else begin
              r_dist <= div_dd[20:0];
            end
            state <= S_LH;
          end
        end
        S_LH: begin
          if (!div_run) begin
            if (r_dist == '0) begin
              r_lh  <= LH_MAX;
              state <= S_TEXMUL;
            end
          end else if (div_cnt == '0) begin
            r_lh  <= (div_dd > DDW'(LH_MAX)) ? LH_MAX : div_dd[15:0];
            state <= S_TEXMUL;
          end
        end
        S_TEXMUL: begin
          r_ds  <= (hh_w > lh2) ? 10'(hh_w - lh2) : 10'd0;
          r_de  <= (de_sum >= 16'(h_c)) ? 10'(h_c - 11'd1) : 10'(de_sum);
          state <= S_TEX;
        end
        S_TEX: begin
          r_texcol <= 6'(texm);
          r_status <= ST_WALL;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= r_status;
            if (r_status == ST_WALL) begin
              m_tdata <= {4'd0, side, r_texcol, hit_cell - 4'd1, r_de, r_ds, r_lh, r_dist};
            end else begin
              m_tdata <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous one still in work");
  a_clear_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("ready during map clearing pass");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (steps < SCW'(MAX_STEPS)))
    else $error("walk exceeded the step bound");

endmodule

@@ tb/tb_grid_ray_cast_column.sv @@
// Self-checking testbench for the grid ray caster column unit with a scoreboard and random stimulus.
module tb_grid_ray_cast_column;
  import grc_pkg::*;

  typedef struct {
    logic [20:0] distance;
    logic [15:0] height;
    logic [9:0]  row_first;
    logic [9:0]  row_last;
    logic [3:0]  texture;
    logic [5:0]  tex_col;
    logic        side;
    logic [1:0]  status;
  } column_result_t;

  class column_scoreboard;
    logic [3:0]     cells [32][32];
    longint         pos_x, pos_y, dir_x, dir_y, pln_x, pln_y, scr_w, scr_h;
    column_result_t pending [$];
    int             errors, casts, hits, writes, checked;

    function new();
      foreach (cells[i, j]) cells[i][j] = 4'd0;
      pos_x = 0; pos_y = 0; dir_x = 16384; dir_y = 0;
      pln_x = 0; pln_y = 10813; scr_w = 640; scr_h = 480;
    endfunction

    function longint sext16(longint v);
      v = v & 16'hFFFF;
      return (v >= 32768) ? v - 65536 : v;
    endfunction

    function void set_reg(logic [2:0] idx, longint v);
      case (idx)
        REG_PLAYER_X:      pos_x = v & 21'h1FFFFF;
        REG_PLAYER_Y:      pos_y = v & 21'h1FFFFF;
        REG_VIEW_DIR_X:    dir_x = sext16(v);
        REG_VIEW_DIR_Y:    dir_y = sext16(v);
        REG_PLANE_X:       pln_x = sext16(v);
        REG_PLANE_Y:       pln_y = sext16(v);
        REG_SCREEN_WIDTH:  scr_w = v & 11'h7FF;
        REG_SCREEN_HEIGHT: scr_h = v & 11'h7FF;
        default: ;
      endcase
    endfunction

    function longint floor14(longint x);
      return (x >= 0) ? (x >>> 14) : -(((-x) + 16383) >>> 14);
    endfunction

    function longint absval(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function longint clamp_scr(longint v);
      return (v < 1) ? 1 : ((v > 1024) ? 1024 : v);
    endfunction

    function column_result_t cast_column(longint col);
      column_result_t r;
      longint w, h, cam, rx, ry, mx, my, sx, sy, dx, dy, sdx, sdy, fx, fy;
      longint num, rd, perp, lh, ds, de, wall, texx;
      bit vx, vy, hit;
      int side, n;
      logic [3:0] hit_val;
      r = '{default: '0};
      w = clamp_scr(scr_w); h = clamp_scr(scr_h);
      hit = 0; side = 0; hit_val = 0; dx = 0; dy = 0; sdx = 0; sdy = 0;
      if (col > w - 1) col = w - 1;
      cam = (col * 32768) / w - 16384;
      rx = dir_x + floor14(pln_x * cam);
      ry = dir_y + floor14(pln_y * cam);
      mx = pos_x >> 16; my = pos_y >> 16;
      fx = pos_x & 16'hFFFF; fy = pos_y & 16'hFFFF;
      vx = rx != 0; vy = ry != 0;
      sx = (rx < 0) ? -1 : 1;
      sy = (ry < 0) ? -1 : 1;
      if (vx) begin
        dx = (64'd1 << 30) / absval(rx);
        sdx = (((rx < 0) ? fx : 65536 - fx) * dx) >> 16;
      end
      if (vy) begin
        dy = (64'd1 << 30) / absval(ry);
        sdy = (((ry < 0) ? fy : 65536 - fy) * dy) >> 16;
      end
      if (vx || vy) begin
        for (n = 0; n < 64; n++) begin
          if (vx && (!vy || sdx < sdy)) begin
            sdx += dx; mx += sx; side = 0;
          end else begin
            sdy += dy; my += sy; side = 1;
          end
          if (mx < 0 || mx >= 32 || my < 0 || my >= 32) break;
          hit_val = cells[mx][my];
          if (hit_val != 0) begin
            hit = 1;
            break;
          end
        end
      end
      if (!hit) begin
        r.status = ST_NOWALL;
        return r;
      end
      if (side == 0) num = mx * 65536 - pos_x + ((sx < 0) ? 65536 : 0);
      else num = my * 65536 - pos_y + ((sy < 0) ? 65536 : 0);
      rd = (side == 0) ? rx : ry;
      if (((num < 0) != (rd < 0)) && num != 0) perp = 0;
      else perp = (absval(num) << 14) / absval(rd);
      if (perp > 2097151) perp = 2097151;
      lh = (perp == 0) ? 65535 : (h << 16) / perp;
      if (lh > 65535) lh = 65535;
      ds = h / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = h / 2 + lh / 2;
      if (de >= h) de = h - 1;
      if (side == 0) wall = pos_y + floor14(perp * ry);
      else wall = pos_x + floor14(perp * rx);
      texx = ((wall & 16'hFFFF) * 64) >> 16;
      if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) texx = 64 - texx - 1;
      r.distance = 21'(perp); r.height = 16'(lh); r.row_first = 10'(ds); r.row_last = 10'(de);
      r.texture = hit_val - 4'd1; r.tex_col = 6'(texx); r.side = 1'(side);
      r.status = ST_WALL;
      return r;
    endfunction

    function void note_request(logic kind, logic [23:0] data);
      column_result_t r;
      if (kind == KIND_WRITE) begin
        cells[data[14:10]][data[19:15]] = data[23:20];
        r = '{default: '0};
        r.status = ST_WRITE;
        writes++;
      end else begin
        r = cast_column(data[9:0]);
        casts++;
        if (r.status == ST_WALL) hits++;
      end
      pending = {pending, r};
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH on result %0d: %s got %0d expected %0d", checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [71:0] d, logic [1:0] st);
      column_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result with status", st, 0);
        return;
      end
      e = pending.pop_front();
      if (d[20:0] !== e.distance) report("wall_distance", d[20:0], e.distance);
      if (d[36:21] !== e.height) report("line_height", d[36:21], e.height);
      if (d[46:37] !== e.row_first) report("draw_start", d[46:37], e.row_first);
      if (d[56:47] !== e.row_last) report("draw_end", d[56:47], e.row_last);
      if (d[60:57] !== e.texture) report("wall_texture", d[60:57], e.texture);
      if (d[66:61] !== e.tex_col) report("tex_column", d[66:61], e.tex_col);
      if (d[67] !== e.side) report("hit_side", d[67], e.side);
      if (st !== e.status) report("status", st, e.status);
      checked++;
    endtask
  endclass

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tuser = 0, m_tready = 0, cfg_we = 0;
  logic        s_tready, m_tvalid;
  logic [23:0] s_tdata = '0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic [2:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;

  column_scoreboard sb = new();
  int send_gap_pct = 0, recv_stall_pct = 0, quiet = 0;

  grid_ray_cast_column u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Timeout: no handshake for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  task write_reg(logic [2:0] idx, longint v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v[20:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task load_view(longint px, py, dxv, dyv, plx, ply, w, h);
    write_reg(REG_PLAYER_X, px); write_reg(REG_PLAYER_Y, py);
    write_reg(REG_VIEW_DIR_X, dxv); write_reg(REG_VIEW_DIR_Y, dyv);
    write_reg(REG_PLANE_X, plx); write_reg(REG_PLANE_Y, ply);
    write_reg(REG_SCREEN_WIDTH, w); write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  task send_request(logic kind, logic [23:0] data);
    int gap;
    gap = 0;
    if ($urandom_range(99, 0) < send_gap_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= kind; s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, data);
  endtask

  task send_write(int x, int y, int v);
    send_request(KIND_WRITE, {v[3:0], y[4:0], x[4:0], 10'd0});
  endtask

  task send_cast(int col);
    send_request(KIND_CAST, {14'($urandom_range(16383, 0)), col[9:0]});
  endtask

  task drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task random_requests(int count);
    int k, e;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99, 0) < 35) begin
        e = $urandom_range(31, 0);
        case ($urandom_range(3, 0))
          0: send_write(0, e, $urandom_range(15, 1));
          1: send_write(31, e, $urandom_range(15, 1));
          2: send_write(e, $urandom_range(1, 0) * 31, $urandom_range(15, 1));
          default: send_write($urandom_range(31, 0), $urandom_range(31, 0),
                              ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 0));
        endcase
      end else begin
        send_cast($urandom_range(1023, 0));
      end
    end
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst <= 0;
    do @(posedge clk); while (!s_tready);

    send_cast(320);
    send_write(20, 16, 15);
    send_write(31, 31, 1);
    send_write(0, 0, 0);
    drain();
    load_view(32'h108000, 32'h108000, 16384, 0, 0, 10813, 640, 480);
    send_cast(0); send_cast(320); send_cast(639); send_cast(1023);
    send_write(20, 16, 0);
    send_cast(320);
    drain();
    load_view(32'h1FFFFF, 0, 32767, 32767, 32767, -32768, 0, 0);
    send_cast(0); send_cast(1023);
    drain();
    load_view(32'h1F8000, 32'h008000, -32768, 16384, 0, 0, 2047, 2047);
    send_write(0, 0, 2); send_write(1, 0, 3);
    send_cast(0); send_cast(1023); send_cast(512);
    drain();
    load_view(32'h100000, 32'h100000, 0, 0, 0, 0, 1024, 1024);
    send_cast(512);
    drain();

    for (p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin send_gap_pct = 21; recv_stall_pct = 60; end
        1: begin send_gap_pct = 60; recv_stall_pct = 21; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      load_view($urandom_range(30, 1) * 65536 + $urandom_range(65535, 0),
                $urandom_range(30, 1) * 65536 + $urandom_range(65535, 0),
                $urandom_range(65535, 0), $urandom_range(65535, 0),
                $urandom_range(65535, 0), $urandom_range(65535, 0),
                ($urandom_range(3, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(1024, 1),
                ($urandom_range(3, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(1024, 1));
      random_requests(205);
      drain();
    end

    $display("Covered %0d map writes and %0d column casts, %0d of which hit a wall.",
             sb.writes, sb.casts, sb.hits);
    $display("Checked %0d results across 13 view settings, mismatches: %0d.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/grc_pkg.sv
hdl/grid_ray_cast_column.sv
tb/tb_grid_ray_cast_column.sv
